@@ hw/rtl/miller_rabin_prime_test_top_defines.svh @@
// assertion macros for the top-level rtl
`ifndef MILLER_RABIN_PRIME_TEST_TOP_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_TOP_DEFINES_SVH

// property that holds whenever reset is released
`define MRPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define MRPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mrpt_pkg.sv @@
package mrpt_pkg;
	localparam int unsigned WIDTH = 64;
	localparam int unsigned RW = 7;
	localparam int unsigned DW = 31;
	localparam int unsigned SW = $clog2(WIDTH + 1);
	localparam logic [RW-1:0] ROUNDS_RESET = 7'd5;

	typedef struct packed {
		logic [63:0] candidate;
		logic [30:0] random_draw;
	} in_item_t;

	typedef struct packed {
		logic        is_probable_prime;
		logic [63:0] tested_value;
	} out_item_t;

	// requests to the modular unit
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_MOD = 2'd1
	} mop_t;

	typedef struct packed {
		logic start;
		mop_t op;
	} mreq_t;
endpackage

@@ hw/rtl/miller_rabin_prime_test_top.sv @@
// channel | direction | payload    | handshake
// in      | into      | in_item_t  | in_valid / in_stall
// out     | out of    | out_item_t | out_valid / out_stall
// cfg     | into      | rounds     | cfg_we, no wait
// a round is one witness reduction, then 64 squarings, one product per set bit
// of d and up to s-1 more squarings, each run on the shared modular unit;
// the fixed cases (n of 0 to 4) skip the unit
// reset clears the sequencer, round counter, out_valid and rounds (to 5); no clearing pass
// in_stall is high while a round runs; a verdict still waiting in the output
// register holds the next verdict in the end state
module miller_rabin_prime_test_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mrpt_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mrpt_pkg::out_item_t  out_data
);
	import mrpt_pkg::*;

	`include "miller_rabin_prime_test_top_defines.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_SPLIT, S_WIT, S_WITW, S_PSQ, S_PSQW, S_PMUL, S_PMULW, S_CHK,
		S_SQ, S_SQW, S_END
	} st_t;

	st_t st_q;
	logic [RW-1:0] rounds_q, done_q;
	logic comp_q, pass_q;
	logic [WIDTH-1:0] n_q, d_q, a_q, x_q, e_q;
	logic [SW-1:0] s_q, k_q, bit_q;
	mreq_t req;
	logic [WIDTH-1:0] ux, uy, um, ur;
	logic udone;
	logic acc;
	logic [RW-1:0] limit, done_nx;
	logic [WIDTH-1:0] nm1;
	logic fail_nx;
	logic emit;

	mrpt_modunit u_mod (
		.clk(clk), .arst_n(arst_n), .req(req), .x(ux), .y(uy), .m(um),
		.done(udone), .r(ur)
	);

	assign nm1 = n_q - 1'b1;
	assign acc = in_valid && !in_stall;
	assign in_stall = (st_q != S_IDLE);
	assign limit = (rounds_q == '0) ? RW'(1) : rounds_q;
	assign done_nx = done_q + 1'b1;
	assign fail_nx = comp_q || !pass_q;
	assign emit = (st_q == S_END) && (done_nx >= limit) && (!out_valid || !out_stall);

	always_comb begin
		req = '{start: 1'b0, op: OP_MUL};
		ux = x_q;
		uy = x_q;
		um = n_q;
		case (st_q)
			S_WIT: begin
				req = '{start: 1'b1, op: OP_MOD};
				uy = WIDTH'(a_q);
				um = n_q - WIDTH'(4);
			end
			S_PSQ, S_SQ: req = '{start: 1'b1, op: OP_MUL};
			S_PMUL: begin
				req = '{start: 1'b1, op: OP_MUL};
				uy = a_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rounds_q <= ROUNDS_RESET;
			done_q <= '0;
			comp_q <= 1'b0;
			out_valid <= 1'b0;
			n_q <= '0;
		end else begin
			if (cfg_we)
				rounds_q <= cfg_wdata;
			if (emit)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						if (done_q == '0) begin
							n_q <= in_data.candidate[WIDTH-1:0];
							comp_q <= 1'b0;
						end
						a_q <= WIDTH'(in_data.random_draw);
						st_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					d_q <= nm1;
					s_q <= '0;
					if (n_q <= WIDTH'(1) || n_q == WIDTH'(4)) begin
						pass_q <= 1'b0;
						st_q <= S_END;
					end else if (n_q <= WIDTH'(3)) begin
						pass_q <= 1'b1;
						st_q <= S_END;
					end else begin
						st_q <= S_WIT;
					end
				end
				S_WIT: begin
					// strip one factor of two per cycle meanwhile
					if (!d_q[0] && d_q != '0) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end
					st_q <= S_WITW;
				end
				S_WITW: begin
					if (!d_q[0] && d_q != '0) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end
					if (udone) begin
						a_q <= ur + WIDTH'(2);
						x_q <= WIDTH'(1);
						bit_q <= SW'(WIDTH);
						st_q <= S_PSQ;
					end
				end
				S_PSQ: begin
					e_q <= d_q << (SW'(WIDTH) - bit_q);
					st_q <= S_PSQW;
				end
				S_PSQW: begin
					if (udone) begin
						x_q <= ur;
						st_q <= e_q[WIDTH-1] ? S_PMUL : S_CHK;
					end
				end
				S_PMUL: st_q <= S_PMULW;
				S_PMULW: begin
					if (udone) begin
						x_q <= ur;
						st_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (bit_q != SW'(1)) begin
						bit_q <= bit_q - 1'b1;
						st_q <= S_PSQ;
					end else if (x_q == WIDTH'(1) || x_q == nm1) begin
						pass_q <= 1'b1;
						st_q <= S_END;
					end else begin
						k_q <= SW'(1);
						bit_q <= '0;
						if (s_q <= SW'(1)) begin
							pass_q <= 1'b0;
							st_q <= S_END;
						end else begin
							st_q <= S_SQ;
						end
					end
				end
				S_SQ: st_q <= S_SQW;
				S_SQW: begin
					if (udone) begin
						x_q <= ur;
						k_q <= k_q + 1'b1;
						if (ur == nm1) begin
							pass_q <= 1'b1;
							st_q <= S_END;
						end else if (ur == WIDTH'(1) || k_q + 1'b1 >= s_q) begin
							pass_q <= 1'b0;
							st_q <= S_END;
						end else begin
							st_q <= S_SQ;
						end
					end
				end
				S_END: begin
					if (done_nx >= limit) begin
						// wait here while the previous verdict is still stalled
						if (emit) begin
							out_data.is_probable_prime <= !fail_nx;
							out_data.tested_value <= 64'(n_q);
							done_q <= '0;
							comp_q <= 1'b0;
							st_q <= S_IDLE;
						end
					end else begin
						done_q <= done_nx;
						comp_q <= fail_nx;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`MRPT_ASSERT(a_busy_stall, (st_q != S_IDLE) |-> in_stall, "input taken while busy")
	`MRPT_ASSERT_NEXT(a_acc_busy, acc, st_q == S_SPLIT, "accepted item not started")
	`MRPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result dropped")
endmodule

@@ hw/rtl/mrpt_modunit.sv @@
// shared modular unit: x*y mod m by shift-and-add, or y mod m by restoring division
module mrpt_modunit (
	input  logic             clk,
	input  logic             arst_n,
	input  mrpt_pkg::mreq_t  req,
	input  logic [mrpt_pkg::WIDTH-1:0] x,
	input  logic [mrpt_pkg::WIDTH-1:0] y,
	input  logic [mrpt_pkg::WIDTH-1:0] m,
	output logic             done,
	output logic [mrpt_pkg::WIDTH-1:0] r
);
	import mrpt_pkg::*;

	typedef enum logic [1:0] {IDLE, MUL, DIV} st_t;
	st_t st_q;
	logic [WIDTH-1:0] r_q, x_q, y_q, m_q;
	logic [SW-1:0] cnt_q;
	logic [WIDTH:0] dbl, dsum, rem;
	logic [WIDTH-1:0] step1;

	always_comb begin
		// r + r mod m, then optional + x mod m
		dbl = {r_q, 1'b0};
		step1 = (dbl >= {1'b0, m_q}) ? WIDTH'(dbl - {1'b0, m_q}) : dbl[WIDTH-1:0];
		dsum = {1'b0, step1} + {1'b0, x_q};
		if (dsum >= {1'b0, m_q})
			dsum = dsum - {1'b0, m_q};
		// restoring division: shift in next bit of y
		rem = {r_q, y_q[WIDTH-1]};
		if (rem >= {1'b0, m_q})
			rem = rem - {1'b0, m_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				IDLE: begin
					if (req.start) begin
						r_q <= '0;
						x_q <= x;
						y_q <= y;
						m_q <= m;
						cnt_q <= SW'(WIDTH);
						st_q <= (req.op == OP_MUL) ? MUL : DIV;
					end
				end
				MUL: begin
					r_q <= y_q[WIDTH-1] ? dsum[WIDTH-1:0] : step1;
					y_q <= y_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == SW'(1)) begin
						done <= 1'b1;
						st_q <= IDLE;
					end
				end
				DIV: begin
					r_q <= rem[WIDTH-1:0];
					y_q <= y_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == SW'(1)) begin
						done <= 1'b1;
						st_q <= IDLE;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign r = r_q;
endmodule

@@ bench/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mrpt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 12_000_000;
	localparam int unsigned ROUND_LATENCY = 20_000;
	localparam int unsigned HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	miller_rabin_prime_test_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	in_item_t pending_items[$];
	out_item_t verdict_q[$];
	bit running = 1'b0;
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	int unsigned idle_pct = 46;
	bit hold_phase = 1'b0;
	int unsigned hold_count = 0;
	int unsigned cycles = 0;
	int unsigned errors = 0;

	// predictor state
	logic [6:0] rounds_cfg = ROUNDS_RESET;
	logic [6:0] rounds_seen = '0;
	bit failed_round = 1'b0;
	logic [63:0] latched_n = '0;

	function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return 64'(p % {64'd0, m});
	endfunction

	function automatic bit round_passes(logic [63:0] n, logic [30:0] draw);
		logic [63:0] d, a, x, base;
		int unsigned s;
		d = n - 64'd1;
		s = 0;
		while (d[0] == 1'b0 && d != 0) begin
			d = d >> 1;
			s++;
		end
		a = 64'd2 + {33'd0, draw} % (n - 64'd4);
		base = a % n;
		x = 64'd1 % n;
		for (int i = 63; i >= 0; i--) begin
			x = mul_mod(x, x, n);
			if (d[i]) x = mul_mod(x, base, n);
		end
		if (x == 1 || x == n - 64'd1) return 1'b1;
		for (int k = 1; k < s; k++) begin
			x = mul_mod(x, x, n);
			if (x == n - 64'd1) return 1'b1;
			if (x == 1) return 1'b0;
		end
		return 1'b0;
	endfunction

	task automatic predict_verdict(in_item_t it);
		logic [6:0] limit;
		bit pass;
		limit = (rounds_cfg == 0) ? 7'd1 : rounds_cfg;
		if (rounds_seen == 0) begin
			latched_n = it.candidate;
			failed_round = 1'b0;
		end
		if (latched_n <= 1 || latched_n == 4) pass = 1'b0;
		else if (latched_n <= 3) pass = 1'b1;
		else pass = round_passes(latched_n, it.random_draw);
		if (!pass) failed_round = 1'b1;
		rounds_seen = rounds_seen + 7'd1;
		if (rounds_seen >= limit) begin
			verdict_q.push_back('{is_probable_prime: !failed_round, tested_value: latched_n});
			rounds_seen = '0;
			failed_round = 1'b0;
		end
	endtask

	task automatic report(string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	// driver
	always @(posedge clk) begin
		if (running) begin
			if (in_valid && !in_stall) predict_verdict(in_data);
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && !(send_idle && $urandom_range(99) < idle_pct)) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off on the output side
	always @(posedge clk) begin
		if (hold_phase && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
	end

	// monitor
	always @(posedge clk) begin
		if (running) begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					report($sformatf("unexpected verdict for %0d", out_data.tested_value));
				end else begin
					out_item_t want;
					want = verdict_q.pop_front();
					if (out_data.is_probable_prime !== want.is_probable_prime)
						report($sformatf("verdict for %0d is %b, want %b", want.tested_value,
							out_data.is_probable_prime, want.is_probable_prime));
					if (out_data.tested_value !== want.tested_value)
						report($sformatf("tested_value %0d, want %0d", out_data.tested_value,
							want.tested_value));
				end
			end
			out_stall <= (hold_phase && hold_count < HOLD_CYCLES) ||
				(recv_idle && $urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic push_candidate(logic [63:0] n, int unsigned items);
		for (int i = 0; i < items; i++) begin
			in_item_t it;
			it.candidate = (i == 0) ? n : {$urandom, $urandom};
			it.random_draw = 31'($urandom);
			pending_items.push_back(it);
		end
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !in_valid);
		wait (verdict_q.size() == 0);
		// a round that yields no verdict may still be running
		if (rounds_seen != 0) repeat (ROUND_LATENCY) @(posedge clk);
		else repeat (10) @(posedge clk);
	endtask

	task automatic write_rounds(logic [6:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		rounds_cfg = v;
	endtask

	task automatic set_idling(int unsigned mode);
		send_idle = (mode == 1 || mode == 3);
		recv_idle = (mode == 2 || mode == 3);
		idle_pct = (mode == 3) ? 31 : 46;
	endtask

	function automatic logic [63:0] pick_candidate();
		logic [63:0] known[8];
		int unsigned r;
		known = '{64'd5, 64'd7, 64'd561, 64'd2047, 64'd6, 64'd2305843009213693951,
			64'd18446744073709551557, 64'd1000000007};
		r = $urandom_range(99);
		if (r < 35) return 64'($urandom_range(4));
		if (r < 60) return known[$urandom_range(7)];
		return {$urandom, $urandom} | 64'd1;
	endfunction

	initial begin
		int unsigned sent;
		int unsigned rnds;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		// reset value of rounds, fixed cases and known values
		set_idling(0);
		push_candidate(64'd0, 5);
		push_candidate(64'd2, 5);
		push_candidate(64'd7, 5);
		drain();

		write_rounds(7'd1);
		set_idling(3);
		push_candidate(64'd1, 1);
		push_candidate(64'd3, 1);
		push_candidate(64'd4, 1);
		push_candidate(64'd5, 1);
		push_candidate(64'd6, 1);
		push_candidate(64'd561, 1);
		push_candidate(64'd2047, 1);
		push_candidate(64'hFFFF_FFFF_FFFF_FFFF, 1);
		push_candidate(64'd18446744073709551557, 1);
		drain();

		// zero behaves as one
		write_rounds(7'd0);
		set_idling(1);
		push_candidate(64'd2305843009213693951, 1);
		push_candidate(64'd9, 1);
		drain();

		// rounds lowered part way through a candidate
		set_idling(0);
		write_rounds(7'd3);
		push_candidate(64'd1000000007, 2);
		drain();
		write_rounds(7'd1);
		push_candidate(64'd8, 1);
		drain();

		// output held off while the input keeps offering items
		hold_phase = 1'b1;
		for (int i = 0; i < 12; i++) push_candidate(64'($urandom_range(4)), 1);
		drain();
		hold_phase = 1'b0;

		sent = 0;
		for (int ph = 0; sent < 60; ph++) begin
			rnds = $urandom_range(1, 3);
			write_rounds(7'(rnds));
			set_idling(ph % 4);
			for (int c = 0; c < 8; c++) begin
				push_candidate(pick_candidate(), rnds);
				sent += rnds;
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
